>>> rtl/core/fsfl_pkg.sv
// Shared types, codes and widths for the fixed-slot free-list allocator.
package fsfl_pkg;

   localparam int NUM_SLOTS_DEF = 1024;

   localparam int SLOT_IN_W   = 10;
   localparam int SLOT_OUT_W  = 10;
   localparam int COUNT_W     = 11;
   localparam int THRESH_W    = 17;
   localparam int CDOWN_W     = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 17;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_THRESHOLD = 1'b1;

   localparam logic [1:0] ST_ALLOC  = 2'd0;
   localparam logic [1:0] ST_FREED  = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_REJECT = 2'd3;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_REJECT
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOAD,
      BK_SWEEP
   } back_state_type;

   typedef struct packed {
      logic                 op;
      logic [SLOT_IN_W-1:0] slot_in;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_OUT_W-1:0] slot_out;
      logic                  threshold_alert;
      logic [COUNT_W-1:0]    free_count;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [SLOT_IN_W-1:0] slot;
   } cmd_type;

   typedef struct packed {
      logic                rebuild;
      logic                rearm;
      logic [COUNT_W-1:0]  slots_in_use;
      logic [THRESH_W-1:0] threshold;
   } cfg_type;

endpackage

>>> rtl/core/fsfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/fsfl_front.sv
// Front end: takes request beats and sorts them into allocate, free and reject commands.
module fsfl_front import fsfl_pkg::*; (
   input  logic               req_valid,
   input  req_type            req_data,
   output logic               req_stall,
   input  logic [COUNT_W-1:0] slots_in_use,
   input  logic               blocked,
   input  logic               queue_full,
   output logic               cmd_push,
   output cmd_type            cmd
);

   always_comb begin
      req_stall = queue_full || blocked;
      cmd_push  = req_valid && !req_stall;
      cmd.slot  = req_data.slot_in;
      priority if (req_data.op == OP_ALLOC) begin
         cmd.kind = CMD_ALLOC;
      end else if (COUNT_W'(req_data.slot_in) < slots_in_use) begin
         cmd.kind = CMD_FREE;
      end else begin
         cmd.kind = CMD_REJECT;
      end
   end

endmodule

>>> rtl/core/fsfl_cmd_fifo.sv
// Short command queue between the front end and the list engine.
module fsfl_cmd_fifo import fsfl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("command queue popped while empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue pushed while full");

endmodule

>>> rtl/core/fsfl_back.sv
// List engine: owns the head, the link store, the counters and the result register.
module fsfl_back import fsfl_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LINK_W = $clog2(NUM_SLOTS + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLOTS);

   back_state_type      state_ff, state_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0]  free_ff, free_in;
   logic [CDOWN_W-1:0]  cdown_ff, cdown_in;
   logic                armed_ff, armed_in;
   logic [SLOT_W-1:0]   sweep_ff, sweep_in;
   rsp_type             pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                ram_wr_en;
   logic [SLOT_W-1:0]   ram_wr_addr;
   logic [LINK_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [LINK_W-1:0]   ram_rd_data;

   logic                out_ready;
   logic                head_nil;
   logic                sweep_last;
   logic [LINK_W-1:0]   sweep_link;
   logic [SLOT_W+SLOT_IN_W-1:0]  slot_ext;
   logic [SLOT_W-1:0]            slot_idx;
   logic [LINK_W+SLOT_OUT_W-1:0] head_ext;
   logic [SLOT_OUT_W-1:0]        head_slot;
   logic                thr_pos;
   logic                thr_neg;
   logic [THRESH_W-1:0] mark;
   logic                alert;

   fsfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NUM_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff[SLOT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign head_nil   = (head_ff == NIL);
   assign sweep_last = ((32'(sweep_ff) + 32'd1) == 32'(cfg.slots_in_use));
   assign sweep_link = sweep_last ? NIL : LINK_W'(sweep_ff) + LINK_W'(1);
   assign slot_ext   = {{SLOT_W{1'b0}}, cmd.slot};
   assign slot_idx   = slot_ext[SLOT_W-1:0];
   assign head_ext   = {{SLOT_OUT_W{1'b0}}, head_ff};
   assign head_slot  = head_ext[SLOT_OUT_W-1:0];
   assign thr_neg    = cfg.threshold[THRESH_W-1];
   assign thr_pos    = !thr_neg && (cfg.threshold != '0);
   assign mark       = ~cfg.threshold + THRESH_W'(1);
   assign busy       = (state_ff == BK_SWEEP);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cfg.rebuild) begin
               state_in = BK_SWEEP;
            end else if (cmd_valid && cmd.kind == CMD_ALLOC && !head_nil) begin
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            if (cfg.rebuild) begin
               state_in = BK_SWEEP;
            end else if (out_ready) begin
               state_in = BK_IDLE;
            end
         end
         BK_SWEEP: begin
            if (sweep_last && !cfg.rebuild) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in      = head_ff;
      free_in      = free_ff;
      cdown_in     = cdown_ff;
      armed_in     = armed_ff;
      sweep_in     = sweep_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = sweep_ff;
      ram_wr_data  = sweep_link;
      ram_rd_en    = 1'b0;
      alert        = 1'b0;

      if (cfg.rearm) begin
         cdown_in = thr_pos ? cfg.threshold[CDOWN_W-1:0] : '0;
         armed_in = (cfg.threshold != '0);
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (!cfg.rebuild && cmd_valid) begin
               unique case (cmd.kind)
                  CMD_ALLOC: begin
                     if (!head_nil) begin
                        // pop the head; the link read finishes next cycle
                        cmd_pop   = 1'b1;
                        ram_rd_en = 1'b1;
                        if (armed_ff) begin
                           if (thr_pos) begin
                              if (cdown_ff > CDOWN_W'(1)) begin
                                 cdown_in = cdown_ff - CDOWN_W'(1);
                              end else begin
                                 alert    = 1'b1;
                                 armed_in = 1'b0;
                                 cdown_in = '0;
                              end
                           end else if (thr_neg) begin
                              if (THRESH_W'(free_ff) <= mark) begin
                                 alert    = 1'b1;
                                 armed_in = 1'b0;
                              end
                           end
                        end
                        free_in = (free_ff != '0) ? free_ff - COUNT_W'(1) : '0;
                        pend_in = '{status: ST_ALLOC, slot_out: head_slot,
                                    threshold_alert: alert, free_count: free_in};
                     end else if (out_ready) begin
                        cmd_pop      = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: ST_EMPTY, slot_out: '0,
                                         threshold_alert: 1'b0, free_count: free_ff};
                     end
                  end
                  CMD_FREE: begin
                     if (out_ready) begin
                        // push the slot on top of the list
                        cmd_pop      = 1'b1;
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = slot_idx;
                        ram_wr_data  = head_ff;
                        head_in      = LINK_W'(slot_idx);
                        free_in      = (free_ff < cfg.slots_in_use) ?
                                       free_ff + COUNT_W'(1) : free_ff;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: ST_FREED, slot_out: '0,
                                         threshold_alert: 1'b0, free_count: free_in};
                     end
                  end
                  CMD_REJECT: begin
                     if (out_ready) begin
                        cmd_pop      = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: ST_REJECT, slot_out: '0,
                                         threshold_alert: 1'b0, free_count: free_ff};
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_LOAD: begin
            if (out_ready) begin
               head_in      = ram_rd_data;
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
            end
         end
         BK_SWEEP: begin
            // relink one slot per cycle
            ram_wr_en = 1'b1;
            sweep_in  = sweep_ff + SLOT_W'(1);
         end
         default: ;
      endcase

      if (cfg.rebuild) begin
         head_in  = '0;
         free_in  = cfg.slots_in_use;
         sweep_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= NIL;
         free_ff      <= '0;
         cdown_ff     <= '0;
         armed_ff     <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         cdown_ff     <= cdown_in;
         armed_ff     <= armed_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_alert_only_on_alloc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.threshold_alert) |-> (rsp_data_ff.status == ST_ALLOC))
      else $error("threshold alert on a non-allocate result");

   a_load_follows_read: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == BK_LOAD) |-> $past(ram_rd_en))
      else $error("link load state entered without a link read");

   a_alert_disarms: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && alert) |=> !armed_ff)
      else $error("alert fired but stayed armed");

   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SWEEP) |-> !cmd_pop)
      else $error("command taken during list rebuild");

endmodule

>>> rtl/core/fixed_slot_free_list_allocator_unit.sv
// Top level: configuration registers, front end, command queue and list engine.
// Result path: a free, a rejected free or an allocate from an empty pool passes through
// the command queue and the result register; a granted allocate adds the link read.
// Throughput: one free per cycle while results are not stalled; an allocate pops the next
// command only after its link read. Reset: synchronous; then the link store is rebuilt
// one slot per cycle; each slots_in_use write repeats this. Requests stall meanwhile.
module fixed_slot_free_list_allocator_unit import fsfl_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_type               req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  rsp_stall,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int SLOTS_MAX = (2 ** COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] SLOTS_RESET =
      COUNT_W'((NUM_SLOTS > SLOTS_MAX) ? SLOTS_MAX : NUM_SLOTS);

   logic [COUNT_W-1:0]  slots_ff, slots_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic                rebuild_ff, rebuild_in;
   logic                rearm_ff, rearm_in;
   logic [COUNT_W-1:0]  slots_raw;

   cfg_type cfg;
   logic    blocked;
   logic    back_busy;
   logic    queue_full;
   logic    cmd_push;
   cmd_type cmd_front;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_back;

   always_comb begin
      slots_raw  = csr_wr_data[COUNT_W-1:0];
      slots_in   = slots_ff;
      thresh_in  = thresh_ff;
      rebuild_in = 1'b0;
      rearm_in   = csr_wr_en;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SLOTS_IN_USE: begin
               rebuild_in = 1'b1;
               // clamp to the managed range
               priority if (slots_raw == '0) begin
                  slots_in = COUNT_W'(1);
               end else if (32'(slots_raw) > NUM_SLOTS) begin
                  slots_in = SLOTS_RESET;
               end else begin
                  slots_in = slots_raw;
               end
            end
            CSR_ALERT_THRESHOLD: begin
               thresh_in = csr_wr_data[THRESH_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff   <= SLOTS_RESET;
         thresh_ff  <= '0;
         rebuild_ff <= 1'b1;
         rearm_ff   <= 1'b0;
      end else begin
         slots_ff   <= slots_in;
         thresh_ff  <= thresh_in;
         rebuild_ff <= rebuild_in;
         rearm_ff   <= rearm_in;
      end
   end

   assign cfg = '{rebuild: rebuild_ff, rearm: rearm_ff,
                  slots_in_use: slots_ff, threshold: thresh_ff};

   // hold requests while configuration settles or the list is rebuilt
   assign blocked = back_busy || rebuild_ff || csr_wr_en;

   fsfl_front u_front (
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .slots_in_use (slots_ff),
      .blocked      (blocked),
      .queue_full   (queue_full),
      .cmd_push     (cmd_push),
      .cmd          (cmd_front)
   );

   fsfl_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_front),
      .full      (queue_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .pop_data  (cmd_back)
   );

   fsfl_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_back),
      .cmd_pop   (cmd_pop),
      .busy      (back_busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

>>> tb/testbench.sv
// Testbench for the free-list slot allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module testbench;
   import fsfl_pkg::*;

   localparam int SLOTS       = NUM_SLOTS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_data = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  rsp_stall = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // allocator image kept by the testbench
   int chain [SLOTS];
   int list_top;
   int spare_count;
   int pool_size;
   int alarm_level;
   int alarm_countdown;
   bit alarm_live;

   req_type request_backlog [$];
   rsp_type alloc_outcomes [$];
   rsp_type oldest_outcome;

   int offered_count = 0;
   int accepted_count = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_go = 1'b0;
   bit hold_started = 1'b0;
   int hold_left = 0;

   fixed_slot_free_list_allocator_unit #(.NUM_SLOTS(SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      if (idx == CSR_SLOTS_IN_USE) begin
         pool_size = int'(value[COUNT_W-1:0]);
         if (pool_size < 1) pool_size = 1;
         if (pool_size > SLOTS) pool_size = SLOTS;
         for (int i = 0; i < pool_size - 1; i++) chain[i] = i + 1;
         chain[pool_size-1] = SLOTS;
         list_top = 0;
         spare_count = pool_size;
      end else begin
         alarm_level = int'(signed'(value));
      end
      // either write re-arms the alert
      alarm_countdown = (alarm_level > 0) ? (alarm_level & 'hFFFF) : 0;
      alarm_live = (alarm_level != 0);
   endfunction

   function automatic rsp_type allocate_or_free(req_type r);
      rsp_type o;
      o = '0;
      if (r.op == OP_ALLOC) begin
         if (list_top >= SLOTS) begin
            o.status = ST_EMPTY;
         end else begin
            if (alarm_live && alarm_level > 0) begin
               if (alarm_countdown > 1) begin
                  alarm_countdown--;
               end else begin
                  o.threshold_alert = 1'b1;
                  alarm_live = 1'b0;
                  alarm_countdown = 0;
               end
            end else if (alarm_live && alarm_level < 0 && spare_count <= -alarm_level) begin
               o.threshold_alert = 1'b1;
               alarm_live = 1'b0;
            end
            o.slot_out = SLOT_OUT_W'(list_top);
            list_top = chain[list_top];
            if (spare_count > 0) spare_count--;
            o.status = ST_ALLOC;
         end
      end else if (int'(r.slot_in) < pool_size) begin
         // push without a double-free check
         chain[r.slot_in] = list_top;
         list_top = int'(r.slot_in);
         if (spare_count < pool_size) spare_count++;
         o.status = ST_FREED;
      end else begin
         o.status = ST_REJECT;
      end
      o.free_count = COUNT_W'(spare_count);
      return o;
   endfunction

   task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // driver: present a new beat only once the previous one is taken
   always @(negedge clock) begin
      if (!reset && !(req_valid && offered_count != accepted_count)) begin
         if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= request_backlog.pop_front();
            req_valid <= 1'b1;
            offered_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (hold_go && !hold_started) begin
         hold_started = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("FAILED: results differ");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) begin
            accepted_count++;
            alloc_outcomes.push_back(allocate_or_free(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (alloc_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected beat: expected none, actual %h", $time, rsp_data);
            end else begin
               oldest_outcome = alloc_outcomes.pop_front();
               check_field("status", 16'(oldest_outcome.status), 16'(rsp_data.status));
               check_field("slot_out", 16'(oldest_outcome.slot_out), 16'(rsp_data.slot_out));
               check_field("threshold_alert", 16'(oldest_outcome.threshold_alert),
                           16'(rsp_data.threshold_alert));
               check_field("free_count", 16'(oldest_outcome.free_count),
                           16'(rsp_data.free_count));
            end
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      apply_csr(idx, value);
   endtask

   // wait until every request is taken and every result is back, then pause
   task automatic settle(int pause);
      while (request_backlog.size() != 0 || offered_count != accepted_count ||
             alloc_outcomes.size() != 0)
         @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   function automatic void queue_req(logic op, logic [SLOT_IN_W-1:0] slot);
      req_type r;
      r.op = op;
      r.slot_in = slot;
      request_backlog.push_back(r);
   endfunction

   // alternate alloc-heavy and free-heavy runs so the pool swings full and empty
   task automatic plan_random(int count, int n);
      int alloc_pct;
      int run_left;
      int pick;
      logic [SLOT_IN_W-1:0] slot;
      alloc_pct = 25;
      run_left = 0;
      for (int k = 0; k < count; k++) begin
         if (run_left == 0) begin
            alloc_pct = (alloc_pct > 50) ? 25 : 75;
            run_left = $urandom_range((n < 56) ? 2 * n + 8 : 120, 4);
         end
         run_left--;
         if ($urandom_range(99) < alloc_pct) begin
            queue_req(OP_ALLOC, SLOT_IN_W'($urandom));
         end else begin
            pick = $urandom_range(99);
            if (pick < 80) slot = SLOT_IN_W'($urandom_range(n - 1));
            else if (pick < 90 && n < SLOTS) slot = SLOT_IN_W'($urandom_range(SLOTS - 1, n));
            else slot = SLOT_IN_W'($urandom);
            queue_req(OP_FREE, slot);
         end
      end
   endtask

   initial begin
      alarm_level = 0;
      apply_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(SLOTS));
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      // let the post-reset list rebuild finish
      settle(SLOTS + 8);

      // single slot (zero clamps to one), alert on first alloc
      send_idle_pct = 18;
      recv_idle_pct = 46;
      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(0));
      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(1));
      queue_req(OP_ALLOC, '0);
      queue_req(OP_ALLOC, '1);
      queue_req(OP_FREE, SLOT_IN_W'(1023));
      queue_req(OP_FREE, SLOT_IN_W'(1));
      queue_req(OP_FREE, SLOT_IN_W'(0));
      queue_req(OP_FREE, SLOT_IN_W'(0));
      queue_req(OP_ALLOC, '0);
      queue_req(OP_ALLOC, '0);
      settle(4);

      // oversized count clamps to the full pool; deepest low-water mark
      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(2047));
      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(-1024));
      queue_req(OP_ALLOC, '1);
      queue_req(OP_ALLOC, '0);
      queue_req(OP_FREE, SLOT_IN_W'(1023));
      queue_req(OP_FREE, SLOT_IN_W'(0));
      queue_req(OP_ALLOC, '0);
      queue_req(OP_ALLOC, '0);
      settle(4);

      // countdown fires on the second alloc, then the pool runs dry
      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(2));
      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(3));
      repeat (4) queue_req(OP_ALLOC, '0);
      queue_req(OP_FREE, SLOT_IN_W'(2));
      queue_req(OP_FREE, SLOT_IN_W'(3));
      queue_req(OP_ALLOC, '0);
      settle(4);

      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(5));
      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(16));
      plan_random(250, 16);
      settle(4);

      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(1));
      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(-1));
      plan_random(100, 1);
      settle(4);

      send_idle_pct = 46;
      recv_idle_pct = 18;
      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(1024));
      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(65535));
      plan_random(250, 1024);
      settle(4);

      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(-50));
      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(200));
      plan_random(250, 200);
      settle(4);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(1025));
      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(300));
      plan_random(250, 1024);
      settle(4);

      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(-1024));
      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(7));
      hold_go = 1'b1;
      plan_random(150, 7);
      settle(4);

      write_csr(CSR_SLOTS_IN_USE, CSR_DATA_W'(64));
      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(-8));
      plan_random(150, 64);
      settle(4);

      // alert off, list left as it stands
      write_csr(CSR_ALERT_THRESHOLD, CSR_DATA_W'(0));
      plan_random(50, 64);
      settle(8);

      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> fixed_slot_free_list_allocator_unit.f
rtl/core/fsfl_pkg.sv
rtl/core/fsfl_ram.sv
rtl/core/fsfl_front.sv
rtl/core/fsfl_cmd_fifo.sv
rtl/core/fsfl_back.sv
rtl/core/fixed_slot_free_list_allocator_unit.sv
tb/testbench.sv
